[src/hmcf_pkg.sv]
// Shared types, constants and saturating fixed-point helpers for the cell flux unit.
`timescale 1ns / 1ps
package hmcf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;

  typedef logic signed [DW-1:0] fix_t;

  localparam fix_t FIX_MAX = 32'sh7FFFFFFF;
  localparam fix_t FIX_MIN = 32'sh80000000;

  localparam logic [2:0] REG_GAMMA = 3'd0;
  localparam logic [2:0] REG_LIGHT = 3'd1;
  localparam logic [2:0] REG_REF   = 3'd2;
  localparam logic [2:0] REG_RLI   = 3'd3;
  localparam logic [2:0] REG_DX    = 3'd4;

  typedef struct packed {
    fix_t ni;
    fix_t mx;
    fix_t my;
    fix_t mz;
    fix_t ei;
    fix_t ne;
    fix_t ee;
    fix_t ex;
    fix_t ey;
    fix_t ez;
    fix_t bx;
    fix_t by;
    fix_t bz;
  } cell_t;

  function automatic fix_t sat64(input logic signed [63:0] v);
    fix_t r;
    if (v > 64'sd2147483647) r = FIX_MAX;
    else if (v < -64'sd2147483648) r = FIX_MIN;
    else r = fix_t'(v[31:0]);
    return r;
  endfunction

  function automatic fix_t add_sat(input fix_t a, input fix_t b);
    logic signed [32:0] s;
    fix_t r;
    s = $signed({a[31], a}) + $signed({b[31], b});
    if (s[32] != s[31]) r = s[32] ? FIX_MIN : FIX_MAX;
    else r = fix_t'(s[31:0]);
    return r;
  endfunction

  function automatic fix_t sub_sat(input fix_t a, input fix_t b);
    logic signed [32:0] s;
    fix_t r;
    s = $signed({a[31], a}) - $signed({b[31], b});
    if (s[32] != s[31]) r = s[32] ? FIX_MIN : FIX_MAX;
    else r = fix_t'(s[31:0]);
    return r;
  endfunction

  function automatic fix_t neg_sat(input fix_t a);
    fix_t r;
    if (a == FIX_MIN) r = FIX_MAX;
    else r = -a;
    return r;
  endfunction

  function automatic fix_t fmul_fix(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> FRAC_BITS;
    return sat64(s);
  endfunction

endpackage

[src/hmcf_div.sv]
// Radix-2 restoring divider: saturated fixed-point quotient, one bit per cycle.
`timescale 1ns / 1ps
module hmcf_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  hmcf_pkg::fix_t           num,
  input  logic signed [32:0]       den,
  output logic                     done,
  output hmcf_pkg::fix_t           quo
);
  import hmcf_pkg::*;

  localparam int NW = DW + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] n_r;
  logic [NW-1:0] q_r;
  logic [32:0]   d_r;
  logic [32:0]   rem_r;
  logic          neg_r;
  fix_t          quo_r;

  logic [31:0]   num_mag;
  logic [32:0]   den_mag;
  logic [33:0]   trial;
  logic [33:0]   diff;
  logic          fits;
  logic          over_pos;
  logic          over_neg;

  always_comb begin
    num_mag  = num[31] ? (~unsigned'(num) + 32'd1) : unsigned'(num);
    den_mag  = den[32] ? (~unsigned'(den) + 33'd1) : unsigned'(den);
    trial    = {rem_r, n_r[NW-1]};
    diff     = trial - {1'b0, d_r};
    fits     = trial >= {1'b0, d_r};
    over_pos = |q_r[NW-1:DW-1];
    over_neg = (|q_r[NW-1:DW]) || (q_r[DW-1] && (|q_r[DW-2:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (den == 33'sd0) begin
          if (num > 0) quo_r <= FIX_MAX;
          else if (num < 0) quo_r <= FIX_MIN;
          else quo_r <= '0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= CW'(NW);
          n_r    <= {num_mag, {FRAC_BITS{1'b0}}};
          d_r    <= den_mag;
          rem_r  <= '0;
          q_r    <= '0;
          neg_r  <= num[31] ^ den[32];
        end
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          rem_r <= fits ? diff[32:0] : trial[32:0];
          q_r   <= {q_r[NW-2:0], fits};
          n_r   <= n_r << 1;
          cnt_r <= cnt_r - CW'(1);
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (neg_r) quo_r <= over_neg ? FIX_MIN : fix_t'(~q_r[DW-1:0] + 32'd1);
          else quo_r <= over_pos ? FIX_MAX : fix_t'(q_r[DW-1:0]);
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[src/hmcf_sqrt.sv]
// Digit-by-digit integer square root of a 64-bit word, two radicand bits per cycle.
`timescale 1ns / 1ps
module hmcf_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);
  import hmcf_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] x_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        fits;

  always_comb begin
    rem_sh = {rem_r, x_r[63:62]};
    trial  = {2'b00, root_r, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
        x_r    <= rad;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        if (cnt_r != 6'd0) begin
          rem_r  <= fits ? 34'(rem_sh - trial) : rem_sh[33:0];
          root_r <= {root_r[30:0], fits};
          x_r    <= x_r << 2;
          cnt_r  <= cnt_r - 6'd1;
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[src/hall_mhd_cell_flux_unit.sv]
// Top level: x-direction two-fluid Hall MHD flux of one grid cell, sequenced over shared units.
`timescale 1ns / 1ps
// One cell is taken per word; its flux record comes out when the next cell arrives, since
// the electron pressure gradient is a forward difference, and a cell marked tlast emits
// the held record and then its own (tlast on the output). A record takes eight quotients
// through the shared one-bit-per-cycle divider, one 32-step square root and twenty
// multiplies; a zero field magnitude skips the current term. The gradient adds one
// multiply and one quotient per cell with a neighbor. in_tready is low while a cell is
// worked on.
module hall_mhd_cell_flux_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // ion_density, ion_momentum_x/y/z, ion_energy, electron_density, electron_energy,
  // electric_x, electric_yz, magnetic_x, magnetic_yz
  input  logic [415:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // mass_flux, momentum_x/y/z_flux, ion_energy_flux, electron_density_flux,
  // electron_energy_flux, electric_y/z_flux, magnetic_y/z_flux
  output logic [351:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import hmcf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_MULWB, S_WAIT, S_OUT} state_t;
  typedef enum logic [1:0] {K_MUL, K_DIV, K_SQRT, K_ALU} kind_t;
  typedef enum logic [4:0] {
    ST_GRAD_MUL, ST_GRAD_DIV, ST_U, ST_V, ST_W, ST_UU, ST_VV, ST_WW,
    ST_HALF, ST_P, ST_MASS, ST_BX, ST_BY, ST_BZ, ST_ROOT, ST_JG,
    ST_JGD, ST_JE, ST_JED, ST_JSUB, ST_RATIO, ST_C2, ST_R1, ST_R2,
    ST_R3, ST_R4, ST_D1, ST_D2, ST_EG, ST_EE, ST_R7, ST_R8
  } step_t;

  state_t state_r;
  step_t  step_r;
  step_t  step_nxt;
  kind_t  kind;

  logic [19:0] gam_r;
  logic [30:0] c0_r;
  logic [30:0] ur_r;
  logic [30:0] rli_r;
  logic [30:0] dx_r;

  cell_t cur_r;
  cell_t held_r;
  cell_t c;
  cell_t in_cell;
  logic  held_valid_r;
  logic  last_r;
  logic  sel_r;

  fix_t grad_r, u_r, v_r, w_r, sq_r, t_r, a_r, p_r, mass_r, j_r, c2_r;
  fix_t r1_r, r2_r, r3_r, r4_r, r6_r, r7_r, r8_r;
  logic [31:0]        b_r;
  logic [63:0]        bsq_r;
  logic signed [63:0] mul_r;

  logic [351:0] out_data_r;
  logic         out_valid_r;
  logic         out_last_r;

  fix_t               opa, opb, g1, fm;
  logic signed [32:0] den;
  logic               wb_en;
  logic               div_start, div_done, sqrt_start, sqrt_done;
  fix_t               div_quo;
  logic [31:0]        sqrt_root;

  hmcf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(opa), .den(den),
    .done(div_done), .quo(div_quo)
  );

  hmcf_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .rad(bsq_r),
    .done(sqrt_done), .root(sqrt_root)
  );

  always_comb begin
    in_cell.ni = fix_t'(in_tdata[31:0]);
    in_cell.mx = fix_t'(in_tdata[63:32]);
    in_cell.my = fix_t'(in_tdata[95:64]);
    in_cell.mz = fix_t'(in_tdata[127:96]);
    in_cell.ei = fix_t'(in_tdata[159:128]);
    in_cell.ne = fix_t'(in_tdata[191:160]);
    in_cell.ee = fix_t'(in_tdata[223:192]);
    in_cell.ex = fix_t'(in_tdata[255:224]);
    in_cell.ey = fix_t'(in_tdata[287:256]);
    in_cell.ez = fix_t'(in_tdata[319:288]);
    in_cell.bx = fix_t'(in_tdata[351:320]);
    in_cell.by = fix_t'(in_tdata[383:352]);
    in_cell.bz = fix_t'(in_tdata[415:384]);
  end

  always_comb begin
    c    = sel_r ? cur_r : held_r;
    g1   = fix_t'({12'd0, gam_r}) - (fix_t'(1) <<< FRAC_BITS);
    fm   = fmul_fix(mul_r);
    kind = K_MUL;
    opa  = c.ni;
    opb  = c.ni;
    den  = {c.ni[31], c.ni};
    case (step_r)
      ST_GRAD_MUL: begin opa = g1; opb = sub_sat(cur_r.ee, held_r.ee); end
      ST_GRAD_DIV: begin kind = K_DIV; opa = t_r; den = {2'b00, dx_r}; end
      ST_U:        begin kind = K_DIV; opa = c.mx; end
      ST_V:        begin kind = K_DIV; opa = c.my; end
      ST_W:        begin kind = K_DIV; opa = c.mz; end
      ST_UU:       begin opa = u_r; opb = u_r; end
      ST_VV:       begin opa = v_r; opb = v_r; end
      ST_WW:       begin opa = w_r; opb = w_r; end
      ST_HALF:     begin opa = c.ni; opb = sq_r; end
      ST_P:        begin opa = g1; opb = sub_sat(c.ei, t_r); end
      ST_MASS:     begin opa = c.ni; opb = u_r; end
      ST_BX:       begin opa = c.bx; opb = c.bx; end
      ST_BY:       begin opa = c.by; opb = c.by; end
      ST_BZ:       begin opa = c.bz; opb = c.bz; end
      ST_ROOT:     kind = K_SQRT;
      ST_JG:       begin opa = fix_t'({1'b0, rli_r}); opb = grad_r; end
      ST_JGD:      begin kind = K_DIV; opa = t_r; den = {1'b0, b_r}; end
      ST_JE:       begin opa = c.ne; opb = c.ex; end
      ST_JED:      begin kind = K_DIV; opa = t_r; den = {1'b0, b_r}; end
      ST_JSUB:     kind = K_ALU;
      ST_RATIO:    begin kind = K_DIV; opa = fix_t'({1'b0, c0_r}); den = {2'b00, ur_r}; end
      ST_C2:       begin opa = t_r; opb = t_r; end
      ST_R1:       begin opa = mass_r; opb = u_r; end
      ST_R2:       begin opa = mass_r; opb = v_r; end
      ST_R3:       begin opa = mass_r; opb = w_r; end
      ST_R4:       begin opa = add_sat(c.ei, p_r); opb = u_r; end
      ST_D1:       begin kind = K_DIV; opa = mass_r; den = {c.ne[31], c.ne}; end
      ST_D2:       begin kind = K_DIV; opa = j_r; den = {c.ne[31], c.ne}; end
      ST_EG:       begin opa = t_r; opb = fix_t'({12'd0, gam_r}); end
      ST_EE:       begin opa = t_r; opb = c.ee; end
      ST_R7:       begin opa = c2_r; opb = c.bz; end
      ST_R8:       begin opa = c2_r; opb = c.by; end
      default:     kind = K_ALU;
    endcase
  end

  always_comb begin
    div_start  = (state_r == S_ISSUE) && (kind == K_DIV);
    sqrt_start = (state_r == S_ISSUE) && (kind == K_SQRT);
    wb_en      = ((state_r == S_ISSUE) && (kind == K_ALU)) || (state_r == S_MULWB) ||
                 ((state_r == S_WAIT) && (div_done || sqrt_done));
    if ((step_r == ST_ROOT) && (sqrt_root == 32'd0)) step_nxt = ST_RATIO;
    else step_nxt = step_t'(step_r + 5'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gam_r <= 20'd109227;
      c0_r  <= 31'd65536;
      ur_r  <= 31'd65536;
      rli_r <= 31'd65536;
      dx_r  <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAMMA: gam_r <= cfg_data[19:0];
        REG_LIGHT: c0_r  <= cfg_data[30:0];
        REG_REF:   ur_r  <= cfg_data[30:0];
        REG_RLI:   rli_r <= cfg_data[30:0];
        REG_DX:    dx_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cur_r  <= in_cell;
            last_r <= in_tlast;
            if (held_valid_r) begin
              sel_r   <= 1'b0;
              step_r  <= ST_GRAD_MUL;
              state_r <= S_ISSUE;
            end else if (in_tlast) begin
              sel_r   <= 1'b1;
              grad_r  <= '0;
              step_r  <= ST_U;
              state_r <= S_ISSUE;
            end else begin
              held_r       <= in_cell;
              held_valid_r <= 1'b1;
            end
          end
        end
        S_ISSUE: begin
          case (kind)
            K_MUL: begin
              mul_r   <= 64'(opa) * 64'(opb);
              state_r <= S_MULWB;
            end
            K_DIV, K_SQRT: state_r <= S_WAIT;
            default: ;
          endcase
        end
        S_MULWB, S_WAIT: ;
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {c.ey, neg_sat(c.ez), r8_r, r7_r, r6_r, sub_sat(mass_r, j_r),
                            r4_r, r3_r, r2_r, r1_r, mass_r};
            out_last_r  <= sel_r;
            out_valid_r <= 1'b1;
            if (!sel_r && last_r) begin
              sel_r   <= 1'b1;
              step_r  <= ST_U;
              state_r <= S_ISSUE;
            end else begin
              state_r <= S_IDLE;
              if (last_r) held_valid_r <= 1'b0;
              else begin
                held_r       <= cur_r;
                held_valid_r <= 1'b1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (wb_en) begin
        case (step_r)
          ST_GRAD_MUL: t_r    <= fm;
          ST_GRAD_DIV: grad_r <= div_quo;
          ST_U:        u_r    <= div_quo;
          ST_V:        v_r    <= div_quo;
          ST_W:        w_r    <= div_quo;
          ST_UU:       sq_r   <= fm;
          ST_VV:       sq_r   <= add_sat(sq_r, fm);
          ST_WW:       sq_r   <= add_sat(sq_r, fm);
          ST_HALF:     t_r    <= fm >>> 1;
          ST_P:        p_r    <= fm;
          ST_MASS:     mass_r <= fm;
          ST_BX:       bsq_r  <= unsigned'(mul_r);
          ST_BY:       bsq_r  <= bsq_r + unsigned'(mul_r);
          ST_BZ:       bsq_r  <= bsq_r + unsigned'(mul_r);
          ST_ROOT: begin
            b_r <= sqrt_root;
            if (sqrt_root == 32'd0) j_r <= mass_r;
          end
          ST_JG:       t_r    <= fm;
          ST_JGD:      a_r    <= div_quo;
          ST_JE:       t_r    <= fm;
          ST_JED:      t_r    <= add_sat(a_r, div_quo);
          ST_JSUB:     j_r    <= neg_sat(sub_sat(t_r, mass_r));
          ST_RATIO:    t_r    <= div_quo;
          ST_C2:       c2_r   <= fm;
          ST_R1:       r1_r   <= add_sat(fm, p_r);
          ST_R2:       r2_r   <= fm;
          ST_R3:       r3_r   <= fm;
          ST_R4:       r4_r   <= fm;
          ST_D1:       a_r    <= div_quo;
          ST_D2:       t_r    <= sub_sat(a_r, div_quo);
          ST_EG:       t_r    <= fm;
          ST_EE:       r6_r   <= fm;
          ST_R7:       r7_r   <= fm;
          ST_R8:       r8_r   <= neg_sat(fm);
          default: ;
        endcase
        step_r  <= step_nxt;
        state_r <= (step_r == ST_R8) ? S_OUT : S_ISSUE;
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign cfg_ready  = 1'b1;

endmodule

[src/hmcf_checker.sv]
// Port-level checks of the cell flux unit, bound to the top level.
`timescale 1ns / 1ps
module hmcf_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic         out_tlast
);

  // a finished record is not dropped while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // a last cell always produces work, so the input side closes
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still ready after last cell");

  // nothing follows the final record until a new cell is worked on
  a_final_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("word right after final record");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind hall_mhd_cell_flux_unit hmcf_checker u_hmcf_checker (.*);

[dv/hall_mhd_cell_flux_unit_tb.sv]
// Self-checking testbench for the Hall MHD cell flux unit: directed table, then random rows.
`timescale 1ns / 1ps
module hall_mhd_cell_flux_unit_tb;
  import hmcf_pkg::*;

  localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;
  localparam int         N_FLUX           = 11;
  localparam int         RANDOM_CELLS     = 1300;
  localparam int         CALM_CELLS       = 150;
  localparam int         WATCHDOG_LIMIT   = 20000;
  localparam int         SETTLE_CYCLES    = 1200;
  localparam longint     ONE              = 64'sd1 << FRAC_BITS;

  typedef struct {
    fix_t f [N_FLUX];
    bit   fin;
  } flux_rec_t;

  typedef struct {
    cell_t     c;
    bit        last;
    bit        typed;
    flux_rec_t want;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid, in_tready, in_tlast;
  logic [415:0] in_tdata;
  logic         out_tvalid, out_tready, out_tlast;
  logic [351:0] out_tdata;
  logic         cfg_valid, cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;

  always #1 clk = ~clk;

  hall_mhd_cell_flux_unit DUT (.*);

  // predictor state
  bit [19:0] gamma_q = 20'd109227;
  bit [30:0] c0_q = 31'd65536, ur_q = 31'd65536, rli_q = 31'd65536, dx_q = 31'd65536;
  cell_t     held_cell;
  bit        cell_held = 1'b0;
  flux_rec_t flux_q [$];

  int  errors = 0, cells_sent = 0, records_seen = 0, cfg_writes = 0, idle_cycles = 0;
  bit  gaps_on = 1'b0, stall_on = 1'b0;
  dir_row_t dir_rows [$];
  string flux_names [N_FLUX] = '{"mass", "mom_x", "mom_y", "mom_z", "ion_energy",
                                 "e_density", "e_energy", "elec_y", "elec_z",
                                 "mag_y", "mag_z"};

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat((a * b) >>> FRAC_BITS);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    if (d == 0) return n > 0 ? 64'sd2147483647 : (n < 0 ? -64'sd2147483648 : 64'sd0);
    return sat((n * ONE) / d);
  endfunction

  function automatic longint field_magnitude(longint bx, longint by, longint bz);
    bit [63:0] x, r, b;
    x = 64'(bx * bx) + 64'(by * by) + 64'(bz * bz);
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint pe_gradient(longint ee_here, longint ee_next);
    longint g1;
    g1 = sat(longint'(gamma_q) - ONE);
    return qdiv(qmul(g1, sat(ee_next - ee_here)), longint'(dx_q));
  endfunction

  function automatic flux_rec_t cell_flux(cell_t c, longint grad, bit fin);
    flux_rec_t o;
    longint gam, g1, ni, ne, u, v, w, sq, half, p, mass, b, t, j, ratio, c2;
    longint r [N_FLUX];
    gam = longint'(gamma_q);
    g1 = sat(gam - ONE);
    ni = c.ni;
    ne = c.ne;
    u = qdiv(c.mx, ni);
    v = qdiv(c.my, ni);
    w = qdiv(c.mz, ni);
    sq = sat(qmul(u, u) + qmul(v, v));
    sq = sat(sq + qmul(w, w));
    half = qmul(ni, sq) >>> 1;
    p = qmul(g1, sat(longint'(c.ei) - half));
    mass = qmul(ni, u);
    b = field_magnitude(c.bx, c.by, c.bz);
    if (b != 0) begin
      t = sat(qdiv(qmul(longint'(rli_q), grad), b) + qdiv(qmul(ne, c.ex), b));
      j = sat(-sat(t - mass));
    end else begin
      j = mass;
    end
    ratio = qdiv(longint'(c0_q), longint'(ur_q));
    c2 = qmul(ratio, ratio);
    r[0] = mass;
    r[1] = sat(qmul(mass, u) + p);
    r[2] = qmul(mass, v);
    r[3] = qmul(mass, w);
    r[4] = qmul(sat(longint'(c.ei) + p), u);
    r[5] = sat(mass - j);
    r[6] = qmul(qmul(sat(qdiv(mass, ne) - qdiv(j, ne)), gam), c.ee);
    r[7] = qmul(c2, c.bz);
    r[8] = sat(-qmul(c2, c.by));
    r[9] = sat(-longint'(c.ez));
    r[10] = c.ey;
    for (int k = 0; k < N_FLUX; k++) o.f[k] = fix_t'(r[k]);
    o.fin = fin;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH record %0d %s: got %0d expected %0d", records_seen, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    flux_rec_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (flux_q.size() == 0) begin
        report_mismatch("unexpected record", 1, 0);
      end else begin
        w = flux_q.pop_front();
        for (int k = 0; k < N_FLUX; k++)
          if (fix_t'(out_tdata[32*k +: 32]) != w.f[k])
            report_mismatch(flux_names[k], fix_t'(out_tdata[32*k +: 32]), w.f[k]);
        if (out_tlast != w.fin) report_mismatch("last", out_tlast, w.fin);
      end
      records_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_cell(cell_t c, bit last, bit typed, flux_rec_t want);
    longint grad;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {c.bz, c.by, c.bx, c.ez, c.ey, c.ex, c.ee, c.ne, c.ei, c.mz, c.my, c.mx, c.ni};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cells_sent++;
    grad = 0;
    if (cell_held) begin
      grad = pe_gradient(held_cell.ee, c.ee);
      flux_q.push_back(cell_flux(held_cell, grad, 1'b0));
    end
    if (last) begin
      flux_q.push_back(typed ? want : cell_flux(c, grad, 1'b1));
      cell_held = 1'b0;
    end else begin
      held_cell = c;
      cell_held = 1'b1;
    end
    @(negedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after its last write
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_GAMMA: gamma_q = val[19:0];
      REG_LIGHT: c0_q = val[30:0];
      REG_REF:   ur_q = val[30:0];
      REG_RLI:   rli_q = val[30:0];
      REG_DX:    dx_q = val[30:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (flux_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_speed(int phase, bit may_zero);
    case (phase == 1 ? 0 : (phase == 2 ? 2 : $urandom_range(0, 5)))
      0: return (may_zero && $urandom_range(0, 1)) ? 32'd0 : 32'd1;
      1: return 32'd65536;
      2: return 32'h7FFF_FFFF;
      3: return $urandom_range(1, 32'h0004_0000);
      default: return {$urandom_range(0, 1) == 1, 31'($urandom)};
    endcase
  endfunction

  task automatic configure(int phase);
    logic [31:0] g;
    case (phase == 1 ? 0 : (phase == 2 ? 1 : $urandom_range(0, 3)))
      0: g = 32'd65536;
      1: g = 32'd655360;
      2: g = 32'hFFFF_FFFF;
      default: g = $urandom_range(65536, 655360) | ($urandom & 32'hFFF0_0000);
    endcase
    write_reg(REG_GAMMA, g);
    write_reg(REG_LIGHT, pick_speed(phase, 1'b0));
    write_reg(REG_REF, pick_speed(phase, 1'b1));
    write_reg(REG_RLI, phase == 1 ? 32'd0 : pick_speed(phase, 1'b1));
    write_reg(REG_DX, pick_speed(phase, 1'b1));
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_UNUSED_FIRST + 3'($urandom_range(0, 2)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic fix_t pick_word(bit wild);
    case (wild ? $urandom_range(0, 9) : $urandom_range(0, 5))
      6: return fix_t'($urandom);
      7: return FIX_MAX;
      8: return FIX_MIN;
      9: return '0;
      default: return fix_t'($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic cell_t pick_cell(bit wild);
    cell_t c;
    c = '{default: '0};
    c.ni = wild ? pick_word(1'b1) : fix_t'($urandom_range(32'h4000, 32'h4_0000));
    c.mx = pick_word(wild);
    c.my = pick_word(wild);
    c.mz = pick_word(wild);
    c.ei = wild ? pick_word(1'b1) : fix_t'($urandom_range(0, 32'h10_0000));
    c.ne = wild ? pick_word(1'b1) : fix_t'($urandom_range(32'h4000, 32'h4_0000));
    c.ee = wild ? pick_word(1'b1) : fix_t'($urandom_range(0, 32'h10_0000));
    c.ex = pick_word(wild);
    c.ey = pick_word(wild);
    c.ez = pick_word(wild);
    if ($urandom_range(0, 7) != 0) begin
      c.bx = pick_word(wild);
      c.by = pick_word(wild);
      c.bz = pick_word(wild);
    end
    return c;
  endfunction

  function automatic void add_row(cell_t c, bit last, bit typed, flux_rec_t want);
    dir_row_t r;
    r.c = c;
    r.last = last;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  function automatic flux_rec_t field_only(fix_t e_y, fix_t e_z, fix_t m_y, fix_t m_z);
    flux_rec_t o;
    foreach (o.f[k]) o.f[k] = '0;
    o.f[7] = m_z;
    o.f[8] = m_y;
    o.f[9] = e_z;
    o.f[10] = e_y;
    o.fin = 1'b1;
    return o;
  endfunction

  initial begin
    cell_t c, z;
    flux_rec_t none;
    int row_len, phase;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    z = '{default: '0};
    none = field_only('0, '0, '0, '0);

    // single-cell rows, answers known at reset settings
    add_row(z, 1, 1, none);
    c = z; c.ey = FIX_MAX; c.ez = FIX_MIN; c.by = FIX_MIN; c.bz = FIX_MAX;
    add_row(c, 1, 1, field_only(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX));
    c = z; c.ey = -1; c.ez = 1; c.by = 32'sh10000; c.bz = -32'sh10000;
    add_row(c, 1, 1, field_only(-1, -1, -32'sh10000, -32'sh10000));
    // two-cell row
    add_row(pick_cell(0), 0, 0, none);
    add_row(pick_cell(0), 1, 0, none);
    // zero densities, both signs of numerator
    c = pick_cell(0); c.ni = '0; c.ne = '0; c.mx = 32'sh30000; c.my = -32'sh20000;
    add_row(c, 0, 0, none);
    c = pick_cell(0); c.ni = '0; c.ne = '0; c.mx = -32'sh30000; c.mz = 32'sh10000;
    add_row(c, 1, 0, none);
    // extremes everywhere
    c = '{default: FIX_MAX};
    add_row(c, 0, 0, none);
    c = '{default: FIX_MIN};
    add_row(c, 0, 0, none);
    c = '{default: -1};
    add_row(c, 1, 0, none);
    // zero field magnitude
    c = pick_cell(0); c.bx = '0; c.by = '0; c.bz = '0;
    add_row(c, 0, 0, none);
    c.ee = FIX_MIN;
    add_row(c, 0, 0, none);
    c.ee = FIX_MAX;
    add_row(c, 1, 0, none);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_cell(dir_rows[i].c, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    drain();

    phase = 0;
    gaps_on = 1'b1;
    stall_on = 1'b1;
    while (cells_sent < RANDOM_CELLS) begin
      if (cells_sent % 110 < 8 || phase < 3) begin
        phase++;
        drain();
        configure(phase);
      end
      if (cells_sent > RANDOM_CELLS - CALM_CELLS) begin
        gaps_on = 1'b0;
        stall_on = 1'b0;
      end
      row_len = $urandom_range(0, 5) == 0 ? $urandom_range(1, 12) : $urandom_range(2, 5);
      for (int k = 0; k < row_len; k++)
        send_cell(pick_cell($urandom_range(0, 4) == 0), k == row_len - 1, 1'b0, none);
    end
    drain();

    $display("%0d cells, %0d flux records checked over %0d settings (%0d register writes)",
             cells_sent, records_seen, phase + 1, cfg_writes);
    $display("covered zero densities, zero field, single-cell rows, extreme registers");
    if (errors == 0 && flux_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d records missing", errors, flux_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
